>>> hdl/armt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// armt_pkg
// Shared types and constants for the address region map table.
// ----------------------------------------------------------------------------
package armt_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned PageBytesDef  = 4096;

  localparam logic [31:0] WinBaseRst  = 32'h6000_0000;
  localparam logic [31:0] WinLimitRst = 32'h8000_0000;

  localparam logic [19:0] PagesMax = 20'hFFFFF;

  localparam logic [1:0] CmdMap   = 2'd0;
  localparam logic [1:0] CmdUnmap = 2'd1;
  localparam logic [1:0] CmdFault = 2'd2;

  localparam logic RegWinBase  = 1'b0;
  localparam logic RegWinLimit = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StShift,
    StWrite,
    StDone
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] vaddr;
    logic [31:0] req_length;
    logic        fixed_place;
    logic        shared_map;
    logic        private_map;
    logic        anonymous_map;
    logic [3:0]  file_handle;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] region_addr;
    logic        needs_writeback;
    logic        hit_anonymous;
    logic [3:0]  hit_file;
    logic [30:0] file_offset;
  } rsp_t;

endpackage

`default_nettype wire

>>> hdl/armt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// armt_if
// Valid/ready channel carrying one beat of a packed payload.
// ----------------------------------------------------------------------------
interface armt_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/address_region_map_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// address_region_map_table_top
// Address-sorted region table: map (fixed or first fit), unmap, fault lookup.
// ----------------------------------------------------------------------------
// One command at a time. A beat is taken in idle. The table is then walked one
// entry a cycle through a single shared add/compare unit, then a decision is
// made. A map or unmap then shifts entries one a cycle to keep the table sorted.
// A successful command then passes the write state, and every command ends in
// the done state; the result is held in an output register. The longest command
// is an unmap of the lowest entry in a full table of sixteen. It is set by the
// entry walk and the shift sweep over the table. Input waits until the result
// beat has gone before the next command is taken. The table holds no valid
// bits: only entries below the fill count are ever used. Window registers sit
// at byte addresses 0 (base) and 4 (limit) of the APB port.
// ----------------------------------------------------------------------------
module address_region_map_table_top #(
  parameter int unsigned MAX_ENTRIES = armt_pkg::MaxEntriesDef,
  parameter int unsigned PAGE_BYTES  = armt_pkg::PageBytesDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  armt_if.sink        req_i,
  armt_if.source      rsp_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import armt_pkg::*;

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned PW = $clog2(PAGE_BYTES);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ENTRIES);

  // Entry packing: base, length, flags, file, pages loaded.
  typedef struct packed {
    logic [31:0] base;
    logic [30:0] len;
    logic [2:0]  flags;
    logic [3:0]  file;
    logic [19:0] pages;
  } ent_t;

  // Table held in flops; the shared unit reads it at one scan address at a time.
  ent_t tbl_q [MAX_ENTRIES];

  logic [31:0] win_base_q, win_limit_q;
  state_e      state_q, state_d;
  req_t        req_q;
  rsp_t        rsp_q, rsp_d;
  logic        rsp_vld_q, rsp_vld_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [32:0] cand_q, cand_d;
  logic        found_q, found_d;
  logic        fail_q, fail_d;

  // APB: always ready, writes land on the access phase.
  assign pready = 1'b1;
  always_comb begin
    prdata = (paddr[2] == RegWinLimit) ? win_limit_q : win_base_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_base_q  <= WinBaseRst;
      win_limit_q <= WinLimitRst;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegWinBase) win_base_q <= pwdata;
      else                        win_limit_q <= pwdata;
    end
  end

  // Shared unit: current entry against the request.
  ent_t        cur;
  logic [32:0] ent_end, lo, hi, rnd_end;
  logic        ovl, va_in;
  logic [IW-1:0] rd_idx;
  assign rd_idx  = idx_q[IW-1:0];
  assign cur     = tbl_q[rd_idx];
  assign ent_end = {1'b0, cur.base} + {2'b0, cur.len};
  assign lo      = req_q.fixed_place ? {1'b0, req_q.vaddr} : cand_q;
  assign hi      = lo + {1'b0, req_q.req_length};
  assign ovl     = (lo < ent_end) && ({1'b0, cur.base} < hi);
  assign va_in   = ({1'b0, req_q.vaddr} < ent_end) && (req_q.vaddr >= cur.base);
  assign rnd_end = (ent_end + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);

  logic aligned, len_bad, accept;
  assign aligned = (req_q.vaddr[PW-1:0] == '0);
  assign len_bad = (req_q.req_length == '0) || req_q.req_length[31];
  assign accept  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == StIdle) && !rsp_vld_q;
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    cand_d    = cand_q;
    found_d   = found_q;
    fail_d    = fail_q;
    rsp_d     = rsp_q;
    rsp_vld_d = rsp_vld_q;
    if (rsp_o.valid && rsp_o.ready) rsp_vld_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          idx_d   = '0;
          pos_d   = '0;
          found_d = 1'b0;
          fail_d  = 1'b0;
          cand_d  = {1'b0, win_base_q};
          state_d = StScan;
        end
      end
      StScan: begin
        // Advance one entry a cycle; decide at the end of the fill.
        if (idx_q < cnt_q) begin
          priority case (req_q.cmd)
            CmdMap: begin
              if (ovl) begin
                if (req_q.fixed_place) fail_d = 1'b1;
                else cand_d = rnd_end;
              end
            end
            CmdUnmap: begin
              if (!found_q && cur.base == req_q.vaddr) begin
                found_d = 1'b1;
                pos_d   = idx_q;
              end
            end
            CmdFault: begin
              if (!found_q && va_in) begin
                found_d = 1'b1;
                pos_d   = idx_q;
              end
            end
            default: ;
          endcase
          idx_d = idx_q + 1'b1;
        end else begin
          rsp_d = '0;
          rsp_d.status = 1'b1;
          state_d = StDone;
          priority case (req_q.cmd)
            CmdMap: begin
              if (cnt_q >= MaxCnt || len_bad || (req_q.shared_map && req_q.private_map)
                  || fail_q
                  || (req_q.fixed_place && (req_q.vaddr < win_base_q
                      || req_q.vaddr >= win_limit_q || !aligned))
                  || (!req_q.fixed_place
                      && (cand_q + {1'b0, req_q.req_length}) > {1'b0, win_limit_q})) begin
                state_d = StDone;
              end else begin
                if (req_q.fixed_place) cand_d = {1'b0, req_q.vaddr};
                idx_d   = cnt_q;
                state_d = StShift;
              end
            end
            CmdUnmap: begin
              if (aligned && found_q) begin
                idx_d   = pos_q;
                state_d = StShift;
              end
            end
            CmdFault: begin
              if (found_q) begin
                idx_d   = pos_q;
                state_d = StWrite;
              end
            end
            default: ;
          endcase
        end
      end
      StShift: begin
        // Map: shift up from the top while the entry below sits at or above cand.
        // Unmap: pull entries down from pos to the end.
        if (req_q.cmd == CmdMap) begin
          if (idx_q != '0 && tbl_q[IW'(idx_q - 1'b1)].base >= cand_q[31:0]) begin
            idx_d = idx_q - 1'b1;
          end else begin
            state_d = StWrite;
          end
        end else begin
          if (idx_q + 1'b1 < cnt_q) idx_d = idx_q + 1'b1;
          else state_d = StWrite;
        end
      end
      StWrite: begin
        rsp_d = '0;
        rsp_d.status = 1'b0;
        state_d = StDone;
        priority case (req_q.cmd)
          CmdMap: begin
            rsp_d.region_addr = cand_q[31:0];
            cnt_d = cnt_q + 1'b1;
          end
          CmdUnmap: begin
            rsp_d.region_addr = req_q.vaddr;
            rsp_d.needs_writeback = found_q && fail_q;
            cnt_d = cnt_q - 1'b1;
          end
          default: begin
            rsp_d.region_addr   = cur.base;
            rsp_d.hit_anonymous = cur.flags[2];
            rsp_d.hit_file      = cur.file;
            rsp_d.file_offset   = 31'(req_q.vaddr - cur.base);
          end
        endcase
      end
      StDone: begin
        rsp_vld_d = 1'b1;
        state_d   = StIdle;
      end
      default: state_d = StIdle;
    endcase
    // Capture the writeback flag of the unmapped entry before it is shifted over.
    if (state_q == StScan && idx_q >= cnt_q && req_q.cmd == CmdUnmap) begin
      fail_d = tbl_q[pos_q[IW-1:0]].flags[0] && !tbl_q[pos_q[IW-1:0]].flags[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    cand_q  <= cand_d;
    found_q <= found_d;
    fail_q  <= fail_d;
    rsp_q   <= rsp_d;
    if (accept) req_q <= req_i.data;
  end

  // Table writes: one entry a cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == StShift) begin
      if (req_q.cmd == CmdMap) begin
        if (idx_q != '0 && tbl_q[IW'(idx_q - 1'b1)].base >= cand_q[31:0])
          tbl_q[rd_idx] <= tbl_q[IW'(idx_q - 1'b1)];
      end else if (idx_q + 1'b1 < cnt_q) begin
        tbl_q[rd_idx] <= tbl_q[IW'(idx_q + 1'b1)];
      end
    end else if (state_q == StWrite) begin
      if (req_q.cmd == CmdMap) begin
        tbl_q[rd_idx].base  <= cand_q[31:0];
        tbl_q[rd_idx].len   <= req_q.req_length[30:0];
        tbl_q[rd_idx].flags <= {req_q.anonymous_map, req_q.private_map, req_q.shared_map};
        tbl_q[rd_idx].file  <= req_q.file_handle;
        tbl_q[rd_idx].pages <= '0;
      end else if (req_q.cmd == CmdFault && cur.pages != PagesMax) begin
        tbl_q[rd_idx].pages <= cur.pages + 1'b1;
      end
    end
  end

  // Fill count never passes the table depth.
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= MaxCnt)
    else $error("fill count overflow");
  // Input is refused while a command is in flight.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !req_i.ready) else $error("ready while busy");
  // A result appears only after the done step.
  a_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_vld_q) |-> $past(state_q) == StDone) else $error("stray result");

endmodule

`default_nettype wire
